@@ src/pte_pkg.sv @@
// shared types, constants and calendar helpers for the packed timestamp converter
package pte_pkg;

   localparam int unsigned DATE_BITS = 16;
   localparam int unsigned SEC_BITS  = 15;
   localparam int unsigned DAY_BITS  = 15;
   localparam int unsigned YEAR_BITS = 12;
   localparam int unsigned CNT_BITS  = 7;
   localparam int unsigned ADJ_BITS  = 9;
   localparam int unsigned DOY_BITS  = 11;

   localparam logic [16:0] SECS_PER_DAY    = 17'd86400;
   localparam logic [14:0] BLOCK_SECS      = 15'd28800;
   localparam logic [14:0] NEW_OFFSET_DAYS = 15'd8765;
   localparam logic [14:0] OLD_OFFSET_DAYS = 15'd5843;
   localparam logic [11:0] NEW_BASE_YEAR   = 12'd1994;
   localparam logic [11:0] OLD_BASE_YEAR   = 12'd1986;
   localparam logic [11:0] EPOCH_YEAR      = 12'd1970;
   localparam logic [11:0] LAST_YEAR       = 12'd2106;
   localparam logic [15:0] SMALL_DATE      = 16'h0003;
   localparam int unsigned NEW_FLAG_BIT    = 15;

   // floor(d/3) = (d * RECIP3) >> RECIP3_SHIFT, exact for every 16-bit d
   localparam logic [16:0] RECIP3       = 17'd43691;
   localparam int unsigned RECIP3_SHIFT = 17;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SECS,
      ST_WALK,
      ST_ADJ,
      ST_FIX,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic divide;
      logic secs;
      logic walk;
      logic adjust;
      logic fix;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic walk_done;
      logic fix_done;
      logic out_free;
   } status_type;

   // gregorian rule reduced to a form exact for 1901..2199, which spans every year this block can reach
   function automatic logic is_leap(input logic [11:0] year);
      is_leap = (year[1:0] == 2'b00) && (year != 12'd2100);
   endfunction

   function automatic logic [8:0] year_len(input logic [11:0] year);
      year_len = is_leap(year) ? 9'd366 : 9'd365;
   endfunction

endpackage

@@ src/pte_req_if.sv @@
// request channel carrying one packed stamp per item
interface pte_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] packed_stamp;

   modport source (output valid, output packed_stamp, input ready);
   modport sink (input valid, input packed_stamp, output ready);
endinterface

@@ src/pte_rsp_if.sv @@
// response channel carrying corrected seconds and utc year per item
interface pte_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] epoch_seconds;
   logic [11:0] utc_year;

   modport source (output valid, output epoch_seconds, output utc_year, input ready);
   modport sink (input valid, input epoch_seconds, input utc_year, output ready);
endinterface

@@ src/packed_timestamp_to_epoch_core.sv @@
// sequence per item: divide, raw seconds, year walk from 1970, correction, day fixup, output
// the day fixup moves the year back or forward when the corrected day falls outside it
// a new request is taken only once the previous result has moved into the response register
// the walk steps one year per cycle, counting the leap/common years for the epoch correction
// the response register frees the sequencer while a result waits for rsp ready
// reset is synchronous, active high: clears the sequencer and response valid only
module packed_timestamp_to_epoch_core (
   input logic clock,
   input logic reset,
   pte_req_if.sink   req_chan,
   pte_rsp_if.source rsp_chan
);

   pte_pkg::cmd_type    cmd;
   pte_pkg::status_type status;

   // sequencer: idle, divide, seconds, year walk, correction, day fixup, output
   pte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath holds the item being converted and the response register
   pte_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_packed_stamp  (req_chan.packed_stamp),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_epoch_seconds (rsp_chan.epoch_seconds),
      .rsp_utc_year      (rsp_chan.utc_year)
   );

endmodule

@@ src/pte_ctrl.sv @@
// sequencer for the stamp conversion steps
module pte_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pte_pkg::status_type status,
   output pte_pkg::cmd_type    cmd
);

   pte_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pte_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pte_pkg::ST_IDLE: begin
            if (req_valid) state_in = pte_pkg::ST_DIV;
         end
         pte_pkg::ST_DIV:  state_in = pte_pkg::ST_SECS;
         pte_pkg::ST_SECS: state_in = pte_pkg::ST_WALK;
         pte_pkg::ST_WALK: begin
            if (status.walk_done) state_in = pte_pkg::ST_ADJ;
         end
         pte_pkg::ST_ADJ:  state_in = pte_pkg::ST_FIX;
         pte_pkg::ST_FIX: begin
            if (status.fix_done) state_in = pte_pkg::ST_OUT;
         end
         pte_pkg::ST_OUT: begin
            if (status.out_free) state_in = pte_pkg::ST_IDLE;
         end
         default:          state_in = pte_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         pte_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         pte_pkg::ST_DIV:  cmd.divide = 1'b1;
         pte_pkg::ST_SECS: cmd.secs = 1'b1;
         pte_pkg::ST_WALK: cmd.walk = !status.walk_done;
         pte_pkg::ST_ADJ:  cmd.adjust = 1'b1;
         pte_pkg::ST_FIX:  cmd.fix = !status.fix_done;
         pte_pkg::ST_OUT:  cmd.out_load = status.out_free;
         default:          cmd = '0;
      endcase
   end

endmodule

@@ src/pte_dp.sv @@
// datapath: date split, raw seconds, year walk, leap correction, day fixup, output register
module pte_dp (
   input  logic                clock,
   input  logic                reset,
   input  logic [31:0]         req_packed_stamp,
   input  pte_pkg::cmd_type    cmd,
   output pte_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [31:0]         rsp_epoch_seconds,
   output logic [11:0]         rsp_utc_year
);

   logic [pte_pkg::DATE_BITS-1:0] date_ff;
   logic [pte_pkg::SEC_BITS-1:0]  sec_ff;
   logic                          new_ff;
   logic                          small_ff;
   logic [31:0]                   prod_ff;
   logic [31:0]                   secs_ff, secs_in;
   logic [pte_pkg::DAY_BITS-1:0]  days_ff, days_in;
   logic [pte_pkg::YEAR_BITS-1:0] year_ff, year_in;
   logic [pte_pkg::CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic signed [pte_pkg::DOY_BITS-1:0] doy_ff, doy_in;
   logic                          rsp_valid_ff;
   logic [31:0]                   rsp_secs_ff;
   logic [11:0]                   rsp_year_ff;

   // raw seconds stage
   logic [pte_pkg::DAY_BITS-1:0]  quot;
   logic [pte_pkg::DAY_BITS-1:0]  base_days;
   logic [16:0]                   quot3;
   logic [15:0]                   rem_full;
   logic [16:0]                   frac;
   logic                          carry;
   logic [31:0]                   day_secs;

   // year walk
   logic [8:0]                    cur_len;
   logic [8:0]                    prev_len;
   logic [11:0]                   base_year;
   logic                          counts;

   // correction stage
   logic signed [pte_pkg::ADJ_BITS-1:0] adj;
   logic signed [26:0]                  adj_secs;
   logic signed [33:0]                  fixed_secs;

   assign quot      = prod_ff[pte_pkg::RECIP3_SHIFT +: pte_pkg::DAY_BITS];
   assign base_days = quot + (new_ff ? pte_pkg::NEW_OFFSET_DAYS : pte_pkg::OLD_OFFSET_DAYS);
   assign quot3     = {1'b0, quot, 1'b0} + {2'b00, quot};
   assign rem_full  = date_ff - quot3[15:0];
   assign frac      = {2'b00, sec_ff} + ({15'd0, rem_full[1:0]} * {2'b00, pte_pkg::BLOCK_SECS});
   assign carry     = (frac >= pte_pkg::SECS_PER_DAY);
   assign day_secs  = {17'd0, base_days} * {15'd0, pte_pkg::SECS_PER_DAY};

   assign cur_len   = pte_pkg::year_len(year_ff);
   assign prev_len  = pte_pkg::year_len(year_ff - 12'd1);
   assign base_year = new_ff ? pte_pkg::NEW_BASE_YEAR : pte_pkg::OLD_BASE_YEAR;
   // old stamps gain a day per leap year, new stamps lose one per common year
   assign counts    = (year_ff >= base_year) && (new_ff != pte_pkg::is_leap(year_ff));

   always_comb begin
      if (small_ff) begin
         adj = 9'sd1;
      end else if (new_ff) begin
         adj = -$signed({2'b00, cnt_ff});
      end else begin
         adj = $signed({2'b00, cnt_ff});
      end
   end

   assign adj_secs   = $signed({{18{adj[8]}}, adj}) * $signed({10'd0, pte_pkg::SECS_PER_DAY});
   assign fixed_secs = $signed({2'b00, secs_ff}) + {{7{adj_secs[26]}}, adj_secs};

   assign status.walk_done = (days_ff < {6'd0, cur_len});
   assign status.fix_done  = !doy_ff[pte_pkg::DOY_BITS-1] && (doy_ff < $signed({2'b00, cur_len}));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         date_ff  <= req_packed_stamp[31:16];
         sec_ff   <= req_packed_stamp[pte_pkg::SEC_BITS-1:0];
         new_ff   <= req_packed_stamp[pte_pkg::NEW_FLAG_BIT];
         small_ff <= (req_packed_stamp[31:16] < pte_pkg::SMALL_DATE);
      end
      if (cmd.divide) begin
         prod_ff <= {16'd0, date_ff} * {15'd0, pte_pkg::RECIP3};
      end
      secs_ff <= secs_in;
      days_ff <= days_in;
      year_ff <= year_in;
      cnt_ff  <= cnt_in;
      doy_ff  <= doy_in;
   end

   always_comb begin
      secs_in = secs_ff;
      days_in = days_ff;
      year_in = year_ff;
      cnt_in  = cnt_ff;
      doy_in  = doy_ff;
      priority if (cmd.secs) begin
         secs_in = day_secs + {15'd0, frac};
         days_in = base_days + {14'd0, carry};
         year_in = pte_pkg::EPOCH_YEAR;
         cnt_in  = '0;
      end else if (cmd.walk) begin
         days_in = days_ff - {6'd0, cur_len};
         year_in = year_ff + 12'd1;
         cnt_in  = cnt_ff + {6'd0, counts};
      end else if (cmd.adjust) begin
         if (fixed_secs[33]) begin
            secs_in = '0;
            year_in = pte_pkg::EPOCH_YEAR;
            doy_in  = '0;
         end else begin
            secs_in = fixed_secs[31:0];
            doy_in  = $signed({2'b00, days_ff[8:0]}) + {{2{adj[8]}}, adj};
         end
      end else if (cmd.fix) begin
         if (doy_ff[pte_pkg::DOY_BITS-1]) begin
            year_in = year_ff - 12'd1;
            doy_in  = doy_ff + $signed({2'b00, prev_len});
         end else begin
            year_in = year_ff + 12'd1;
            doy_in  = doy_ff - $signed({2'b00, cur_len});
         end
      end else begin
         secs_in = secs_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_secs_ff <= secs_ff;
         rsp_year_ff <= year_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_epoch_seconds = rsp_secs_ff;
   assign rsp_utc_year      = rsp_year_ff;

endmodule

@@ src/pte_checker.sv @@
// port-level checks for the converter and their bind to the top level
module pte_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_epoch_seconds,
   input logic [11:0] rsp_utc_year
);

   logic [1:0] pend_ff, pend_in;

   // items taken in but not yet handed out
   always_comb begin
      pend_in = pend_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         pend_in = pend_ff + 2'd1;
      end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_epoch_seconds)
                                  && $stable(rsp_utc_year))
      else $error("response dropped or changed while stalled");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response without a pending item");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("too many items in flight");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new item taken while converting");

   a_year_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_utc_year >= pte_pkg::EPOCH_YEAR
                    && rsp_utc_year <= pte_pkg::LAST_YEAR)
      else $error("utc year out of range");

endmodule

bind packed_timestamp_to_epoch_core pte_checker u_pte_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_epoch_seconds (rsp_chan.epoch_seconds),
   .rsp_utc_year      (rsp_chan.utc_year)
);

@@ sim/epoch_stamp_checker.sv @@
`timescale 1ns / 1ps
// result predictor and scoreboard for the packed timestamp converter
module epoch_stamp_checker (
   input  logic        clock,
   input  logic        reset,
   pte_req_if          req_mon,
   pte_rsp_if          rsp_mon,
   output int unsigned error_count,
   output int unsigned pending_results
);

   localparam longint unsigned DAY_SECS     = 86400;
   localparam longint unsigned BLOCK_SECS   = 28800;
   localparam longint unsigned NEW_DAYS     = 8765;
   localparam longint unsigned OLD_DAYS     = 5843;
   localparam longint unsigned NEW_FIRST_YR = 1994;
   localparam longint unsigned OLD_FIRST_YR = 1986;
   localparam logic [15:0]     FEW_DATES    = 16'h0003;

   typedef struct {
      logic [31:0] seconds;
      logic [11:0] year;
   } epoch_result_t;

   epoch_result_t expected_epochs[$];
   int unsigned   mismatches = 0;

   function automatic logic gregorian_leap(input longint unsigned y);
      gregorian_leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
   endfunction

   // days-to-civil year, valid for any non-negative count of seconds
   function automatic longint unsigned year_from_seconds(input longint unsigned secs);
      longint unsigned z, era, doe, yoe, doy, mp, y;
      z   = secs / DAY_SECS + 64'd719468;
      era = z / 64'd146097;
      doe = z - era * 64'd146097;
      yoe = (doe - doe / 64'd1460 + doe / 64'd36524 - doe / 64'd146096) / 64'd365;
      doy = doe - (64'd365 * yoe + yoe / 64'd4 - yoe / 64'd100);
      mp  = (64'd5 * doy + 64'd2) / 64'd153;
      y   = yoe + era * 64'd400;
      if (mp >= 64'd10) y = y + 64'd1;
      year_from_seconds = y;
   endfunction

   function automatic epoch_result_t stamp_to_epoch(input logic [31:0] stamp);
      logic [15:0]     date;
      logic            new_epoch;
      longint unsigned days, secs, raw_year, first_year, gained, lost, y, yr;
      epoch_result_t   r;
      date       = stamp[31:16];
      new_epoch  = stamp[15];
      days       = date / 16'd3;
      days       = days + (new_epoch ? NEW_DAYS : OLD_DAYS);
      first_year = new_epoch ? NEW_FIRST_YR : OLD_FIRST_YR;
      secs       = days * DAY_SECS + stamp[14:0] + (date % 16'd3) * BLOCK_SECS;
      raw_year   = year_from_seconds(secs);
      gained     = 0;
      lost       = 0;
      for (y = first_year; y < raw_year; y++) begin
         if (gregorian_leap(y)) begin
            if (!new_epoch) gained++;
         end else begin
            if (new_epoch) lost++;
         end
      end
      if (date < FEW_DATES) begin
         secs = secs + DAY_SECS;
      end else begin
         secs = secs + gained * DAY_SECS;
         if (lost * DAY_SECS <= secs) secs = secs - lost * DAY_SECS;
         else secs = 0;
      end
      if (secs > 64'hFFFF_FFFF) secs = 64'hFFFF_FFFF;
      yr        = year_from_seconds(secs);
      r.seconds = secs[31:0];
      r.year    = yr[11:0];
      stamp_to_epoch = r;
   endfunction

   always @(posedge clock) begin : monitor
      epoch_result_t want;
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_epochs.size() == 0) begin
               $error("result item with no stamp outstanding: epoch_seconds %0d utc_year %0d",
                      rsp_mon.epoch_seconds, rsp_mon.utc_year);
               mismatches++;
            end else begin
               want = expected_epochs.pop_front();
               if (rsp_mon.epoch_seconds !== want.seconds) begin
                  $error("epoch_seconds mismatch: expected %0d, actual %0d",
                         want.seconds, rsp_mon.epoch_seconds);
                  mismatches++;
               end
               if (rsp_mon.utc_year !== want.year) begin
                  $error("utc_year mismatch: expected %0d, actual %0d",
                         want.year, rsp_mon.utc_year);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_epochs.push_back(stamp_to_epoch(req_mon.packed_stamp));
      end
      error_count     <= mismatches;
      pending_results <= expected_epochs.size();
   end

endmodule

@@ sim/packed_timestamp_to_epoch_core_test.sv @@
`timescale 1ns / 1ps
// stimulus, clocking and verdict for the packed timestamp converter
module packed_timestamp_to_epoch_core_test;

   // generous watchdog bound for the 1521 items, stalls and hold-offs included
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned DRAIN_CYCLES = 120;
   localparam int unsigned PHASE_ITEMS  = 300;
   localparam int unsigned PHASES       = 5;

   logic clock;
   logic reset;

   pte_req_if req_chan ();
   pte_rsp_if rsp_chan ();

   int unsigned check_errors;
   int unsigned pending_results;
   int unsigned cycle_count = 0;

   // idle and stall percentages and the hold-off toggle, written only by the main sequence
   int unsigned idle_pct  = 0;
   int unsigned stall_pct = 0;
   logic        hold_arm  = 1'b0;

   packed_timestamp_to_epoch_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   epoch_stamp_checker scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .error_count     (check_errors),
      .pending_results (pending_results)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off whenever hold_arm toggles
   initial begin : receiver
      int unsigned hold_left;
      logic        hold_seen;
      hold_left = 0;
      hold_seen = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else if (hold_arm != hold_seen) begin
            hold_seen = hold_arm;
            hold_left = HOLD_CYCLES - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // offer one stamp, with random idle cycles in front, and wait for its acceptance
   task automatic send_stamp(input logic [31:0] stamp);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.packed_stamp <= stamp;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // random stamp, weighted toward small dates, the top of the date range,
   // year boundaries and the extremes of the seconds field
   function automatic logic [31:0] random_stamp();
      logic [31:0] stamp;
      logic        new_epoch;
      int          target_year, days, y, date;
      stamp = $urandom;
      case ($urandom_range(9))
         6: stamp[31:16] = 16'($urandom_range(5));
         7: stamp[31:16] = 16'($urandom_range(65535, 65000));
         8: begin
            // land the raw seconds right around new year's day
            new_epoch   = 1'($urandom_range(1));
            target_year = $urandom_range(2040, new_epoch ? 1996 : 1988);
            days        = 0;
            // every fourth year is leap across 1970..2099
            for (y = 1970; y < target_year; y++) days += (y % 4 == 0) ? 366 : 365;
            date = 3 * (days - (new_epoch ? 8765 : 5843) - 1) + $urandom_range(5);
            stamp[31:16] = 16'(date);
            stamp[15]    = new_epoch;
         end
         9: stamp[14:0] = $urandom_range(1) ? 15'h7FFF : 15'h0000;
         default: ;
      endcase
      return stamp;
   endfunction

   // directed stamps: field extremes, the small-date boundary and year edges
   logic [31:0] directed_stamps[] = '{
      32'h0000_0000, 32'h0000_8000, 32'h0000_7FFF, 32'h0000_FFFF,
      32'h0001_0000, 32'h0002_FFFF, 32'h0003_0000, 32'h0003_8000,
      32'h0002_8001, 32'h0004_7FFF, 32'hFFFF_0000, 32'hFFFF_FFFF,
      32'hFFFF_7FFF, 32'hFFFF_8000, 32'hFFFE_8123, 32'h8000_0000,
      32'h7FFF_FFFF, 32'h0447_0000, 32'h044A_8000, 32'h5555_2AAA,
      32'hAAAA_D555
   };

   // per phase: sender idle and receiver stall percentages
   int unsigned phase_idle[PHASES]  = '{0, 60, 0, 29, 0};
   int unsigned phase_stall[PHASES] = '{0, 0, 60, 29, 0};

   initial begin : main_sequence
      int unsigned phase_no, n;
      req_chan.valid        <= 1'b0;
      req_chan.packed_stamp <= 32'h0;
      reset                 <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_stamps[i]) send_stamp(directed_stamps[i]);

      for (phase_no = 0; phase_no < PHASES; phase_no++) begin
         idle_pct  <= phase_idle[phase_no];
         stall_pct <= phase_stall[phase_no];
         // long receiver hold-off while stamps keep coming, so the input backs up
         if (phase_no == 2) hold_arm <= ~hold_arm;
         for (n = 0; n < PHASE_ITEMS; n++) send_stamp(random_stamp());
         // quiet pause until every outstanding result has drained
         req_chan.valid <= 1'b0;
         do @(posedge clock); while (pending_results != 0);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (check_errors == 0 && pending_results == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
